[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EBI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define EBI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define EBI_ASSERT(lbl, clk, rstn, prop)
`define EBI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[src/ebi_pkg.sv]
// Types, constants and arithmetic helpers of the Euler body integrator.
package ebi_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DT_W       = 24;
  localparam int SPD_W      = WORD_WIDTH - 1;
  localparam int PROD_W     = 2 * WORD_WIDTH;
  localparam int WIDE_W     = PROD_W + 2;
  localparam int CNT_W      = $clog2(PROD_W);
  localparam int REM_W      = WORD_WIDTH + 3;
  localparam int IDX_W      = 2;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic [WORD_WIDTH-1:0]        uword_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;

  localparam uword_t MASS_RST  = uword_t'(65536);
  localparam logic [SPD_W-1:0] SPEED_RST = SPD_W'(200) << FRAC_BITS;
  localparam prod_t  ONE_SQ    = prod_t'(1) << (2 * FRAC_BITS);
  localparam logic [IDX_W-1:0] IDX_LAST_XYZ = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LAST_XY  = IDX_W'(1);

  localparam wide_t W_MAX = {{(WIDE_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
  localparam wide_t W_MIN = {{(WIDE_W-WORD_WIDTH+1){1'b1}}, {(WORD_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASS      = 2'd0,
    REG_MAX_SPEED = 2'd1,
    REG_FRICTION  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_FORCE    = 2'd0,
    MODE_FRICTION = 2'd1,
    MODE_STEP     = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_FADD,
    OP_MUL_DV,
    OP_DIV_MASS,
    OP_ADD_DV,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_SUM,
    OP_MUL_LIM2,
    OP_CMP_LIM,
    OP_CMP_ONE,
    OP_SQRT,
    OP_SQRT_TAKE,
    OP_MUL_FMAG,
    OP_SET_MAG,
    OP_MUL_SCALE,
    OP_DIV_LEN,
    OP_SET_VEL,
    OP_MUL_DP,
    OP_ADD_POS,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             fric;
  } cmd_t;

  typedef struct packed {
    logic cond;
    logic done;
    logic busy;
  } sts_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t vel_x;
    word_t vel_y;
    word_t vel_z;
    logic  speed_limited;
    logic  saturated;
  } res_t;

  typedef struct packed {
    logic  hit;
    word_t val;
  } sat_t;

  function automatic sat_t sat_word(wide_t x);
    sat_t r;
    r.hit = 1'b0;
    r.val = x[WORD_WIDTH-1:0];
    if (x > W_MAX) begin
      r.hit = 1'b1;
      r.val = W_MAX[WORD_WIDTH-1:0];
    end else if (x < W_MIN) begin
      r.hit = 1'b1;
      r.val = W_MIN[WORD_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic wide_t to_wide(logic neg, prod_t m);
    wide_t w;
    w = $signed({2'b00, m});
    return neg ? -w : w;
  endfunction

  function automatic wide_t ext_word(word_t v);
    return {{(WIDE_W-WORD_WIDTH){v[WORD_WIDTH-1]}}, v};
  endfunction

  function automatic uword_t abs_word(word_t v);
    word_t n;
    n = -v;
    return v[WORD_WIDTH-1] ? uword_t'(n) : uword_t'(v);
  endfunction

endpackage

[src/ebi_iter.sv]
// Bit-serial unsigned divider and digit-by-digit square root unit.
module ebi_iter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_div_i,
  input  logic              start_sqrt_i,
  input  ebi_pkg::prod_t    dividend_i,
  input  ebi_pkg::uword_t   divisor_i,
  input  ebi_pkg::prod_t    radicand_i,
  output logic              busy_o,
  output logic              done_o,
  output ebi_pkg::prod_t    quot_o,
  output ebi_pkg::uword_t   root_o
);
  import ebi_pkg::*;

  logic             busy_q, done_q, sqrt_q;
  logic [CNT_W-1:0] cnt_q;
  prod_t            acc_q;
  logic [REM_W-1:0] rem_q;
  uword_t           den_q, root_q;

  logic [WORD_WIDTH:0] div_sh, div_rem;
  logic                div_ge;
  logic [REM_W-1:0]    sq_sh, sq_trial, sq_rem;
  logic                sq_ge;

  assign div_sh  = {rem_q[WORD_WIDTH-1:0], acc_q[PROD_W-1]};
  assign div_ge  = div_sh >= {1'b0, den_q};
  assign div_rem = div_ge ? div_sh - {1'b0, den_q} : div_sh;

  assign sq_sh    = {rem_q[WORD_WIDTH:0], acc_q[PROD_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_div_i) begin
        busy_q <= 1'b1;
        sqrt_q <= 1'b0;
        cnt_q  <= CNT_W'(PROD_W - 1);
      end else if (start_sqrt_i) begin
        busy_q <= 1'b1;
        sqrt_q <= 1'b1;
        cnt_q  <= CNT_W'(WORD_WIDTH - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_div_i) begin
      acc_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (start_sqrt_i) begin
      acc_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      if (sqrt_q) begin
        rem_q  <= sq_rem;
        root_q <= {root_q[WORD_WIDTH-2:0], sq_ge};
        acc_q  <= acc_q << 2;
      end else begin
        rem_q <= {{(REM_W-WORD_WIDTH-1){1'b0}}, div_rem};
        acc_q <= {acc_q[PROD_W-2:0], div_ge};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = acc_q;
  assign root_o = root_q;

endmodule

[src/ebi_dp.sv]
// Datapath: body state, config registers, multiplier and iterative unit.
module ebi_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ebi_pkg::cmd_t                   cmd_i,
  output ebi_pkg::sts_t                   sts_o,
  input  logic                            cfg_we_i,
  input  logic [ebi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  ebi_pkg::uword_t                 cfg_data_i,
  input  ebi_pkg::word_t                  force_x_i,
  input  ebi_pkg::word_t                  force_y_i,
  input  ebi_pkg::word_t                  force_z_i,
  input  logic [ebi_pkg::DT_W-1:0]        time_step_i,
  output ebi_pkg::res_t                   res_o
);
  import ebi_pkg::*;

  word_t            force_q [3];
  word_t            vel_q [3];
  word_t            pos_q [3];
  uword_t           mass_q;
  logic [SPD_W-1:0] speed_q, coef_q;
  logic             sat_q, lim_q, cond_q;

  word_t            in_f_q [3];
  logic [DT_W-1:0]  dt_q;
  prod_t            prod_q, s2_q;
  logic             neg_q;
  uword_t           len_q, mag_q;
  res_t             res_q;

  uword_t mul_a, mul_b, den;
  prod_t  mul_p, quot, sh;
  uword_t root;
  logic   mul_neg, it_busy, it_done, start_div, start_sqrt;
  word_t  v_sel, f_sel;
  sat_t   fsum [3];
  sat_t   dv, nv, setv, npos;

  assign v_sel = vel_q[cmd_i.idx];
  assign f_sel = force_q[cmd_i.idx];
  assign sh    = prod_q >> FRAC_BITS;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd_i.op)
      OP_MUL_DV: begin
        mul_a   = abs_word(f_sel);
        mul_b   = WORD_WIDTH'(dt_q);
        mul_neg = f_sel[WORD_WIDTH-1];
      end
      OP_SQ_X: begin
        mul_a = abs_word(vel_q[0]);
        mul_b = abs_word(vel_q[0]);
      end
      OP_SQ_Y: begin
        mul_a = abs_word(vel_q[1]);
        mul_b = abs_word(vel_q[1]);
      end
      OP_MUL_LIM2: begin
        mul_a = WORD_WIDTH'(speed_q);
        mul_b = WORD_WIDTH'(speed_q);
      end
      OP_MUL_FMAG: begin
        mul_a = WORD_WIDTH'(coef_q);
        mul_b = WORD_WIDTH'(dt_q);
      end
      OP_MUL_SCALE: begin
        mul_a   = abs_word(v_sel);
        mul_b   = cmd_i.fric ? mag_q : WORD_WIDTH'(speed_q);
        mul_neg = v_sel[WORD_WIDTH-1];
      end
      OP_MUL_DP: begin
        mul_a   = abs_word(v_sel);
        mul_b   = WORD_WIDTH'(dt_q);
        mul_neg = v_sel[WORD_WIDTH-1];
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign start_div  = (cmd_i.op == OP_DIV_MASS) || (cmd_i.op == OP_DIV_LEN);
  assign start_sqrt = (cmd_i.op == OP_SQRT);
  assign den = (cmd_i.op == OP_DIV_MASS) ? ((mass_q == '0) ? uword_t'(1) : mass_q) : len_q;

  ebi_iter u_iter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_div_i  (start_div),
    .start_sqrt_i (start_sqrt),
    .dividend_i   (prod_q),
    .divisor_i    (den),
    .radicand_i   (s2_q),
    .busy_o       (it_busy),
    .done_o       (it_done),
    .quot_o       (quot),
    .root_o       (root)
  );

  always_comb begin
    fsum[0] = sat_word(ext_word(force_q[0]) + ext_word(in_f_q[0]));
    fsum[1] = sat_word(ext_word(force_q[1]) + ext_word(in_f_q[1]));
    fsum[2] = sat_word(ext_word(force_q[2]) + ext_word(in_f_q[2]));
    dv      = sat_word(to_wide(neg_q, quot));
    nv      = sat_word(ext_word(v_sel) + ext_word(dv.val));
    setv    = cmd_i.fric ? sat_word(ext_word(v_sel) - to_wide(neg_q, quot))
                         : sat_word(to_wide(neg_q, quot));
    npos    = sat_word(ext_word(pos_q[cmd_i.idx]) + to_wide(neg_q, sh));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        force_q[i] <= '0;
        vel_q[i]   <= '0;
        pos_q[i]   <= '0;
      end
      mass_q  <= MASS_RST;
      speed_q <= SPEED_RST;
      coef_q  <= '0;
      sat_q   <= 1'b0;
      lim_q   <= 1'b0;
      cond_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MASS:      mass_q  <= cfg_data_i;
          REG_MAX_SPEED: speed_q <= cfg_data_i[SPD_W-1:0];
          REG_FRICTION:  coef_q  <= cfg_data_i[SPD_W-1:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_CAPTURE: begin
          sat_q <= 1'b0;
          lim_q <= 1'b0;
        end
        OP_FADD: begin
          for (int i = 0; i < 3; i++) force_q[i] <= fsum[i].val;
          sat_q <= sat_q | fsum[0].hit | fsum[1].hit | fsum[2].hit;
        end
        OP_ADD_DV: begin
          vel_q[cmd_i.idx] <= nv.val;
          sat_q <= sat_q | dv.hit | nv.hit;
        end
        OP_CMP_LIM: cond_q <= s2_q > prod_q;
        OP_CMP_ONE: cond_q <= s2_q > ONE_SQ;
        OP_SET_VEL: begin
          vel_q[cmd_i.idx] <= setv.val;
          sat_q <= sat_q | setv.hit;
          if (!cmd_i.fric) lim_q <= 1'b1;
        end
        OP_ADD_POS: begin
          pos_q[cmd_i.idx]   <= npos.val;
          force_q[cmd_i.idx] <= '0;
          sat_q <= sat_q | npos.hit;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        in_f_q[0] <= force_x_i;
        in_f_q[1] <= force_y_i;
        in_f_q[2] <= force_z_i;
        dt_q      <= time_step_i;
      end
      OP_MUL_DV, OP_SQ_X, OP_MUL_LIM2, OP_MUL_FMAG, OP_MUL_SCALE, OP_MUL_DP: begin
        prod_q <= mul_p;
        neg_q  <= mul_neg;
      end
      OP_SQ_Y: begin
        s2_q   <= prod_q;
        prod_q <= mul_p;
      end
      OP_SQ_SUM:    s2_q  <= s2_q + prod_q;
      OP_SQRT_TAKE: len_q <= root;
      OP_SET_MAG:   mag_q <= (sh > prod_t'(len_q)) ? len_q : sh[WORD_WIDTH-1:0];
      OP_OUT: begin
        res_q.pos_x         <= pos_q[0];
        res_q.pos_y         <= pos_q[1];
        res_q.pos_z         <= pos_q[2];
        res_q.vel_x         <= vel_q[0];
        res_q.vel_y         <= vel_q[1];
        res_q.vel_z         <= vel_q[2];
        res_q.speed_limited <= lim_q;
        res_q.saturated     <= sat_q;
      end
      default: ;
    endcase
  end

  assign sts_o.cond = cond_q;
  assign sts_o.done = it_done;
  assign sts_o.busy = it_busy;
  assign res_o      = res_q;

endmodule

[src/ebi_ctrl.sv]
// Controller: sequences datapath operations for each input word.
module ebi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     mode_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ebi_pkg::sts_t  sts_i,
  output ebi_pkg::cmd_t  cmd_o
);
  import ebi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FADD,
    S_DV_MUL, S_DV_DIV, S_DV_WAIT, S_DV_ADD,
    S_SQX, S_SQY, S_SQS, S_LIM2, S_CMP_LIM, S_CMP_ONE, S_BRANCH,
    S_SQRT, S_SQRT_WAIT, S_FMAG_MUL, S_FMAG,
    S_CL_MUL, S_CL_DIV, S_CL_WAIT, S_CL_SET,
    S_P_MUL, S_P_ADD, S_DONE
  } state_e;

  state_e           state_q;
  mode_e            mode_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic             can_load, fric;

  assign can_load = !out_valid_q || !out_stall_i;
  assign fric     = (mode_q == MODE_FRICTION);

  always_comb begin
    cmd_o.idx  = idx_q;
    cmd_o.fric = fric;
    case (state_q)
      S_IDLE:      cmd_o.op = in_valid_i ? OP_CAPTURE : OP_NONE;
      S_FADD:      cmd_o.op = OP_FADD;
      S_DV_MUL:    cmd_o.op = OP_MUL_DV;
      S_DV_DIV:    cmd_o.op = OP_DIV_MASS;
      S_DV_ADD:    cmd_o.op = OP_ADD_DV;
      S_SQX:       cmd_o.op = OP_SQ_X;
      S_SQY:       cmd_o.op = OP_SQ_Y;
      S_SQS:       cmd_o.op = OP_SQ_SUM;
      S_LIM2:      cmd_o.op = OP_MUL_LIM2;
      S_CMP_LIM:   cmd_o.op = OP_CMP_LIM;
      S_CMP_ONE:   cmd_o.op = OP_CMP_ONE;
      S_SQRT:      cmd_o.op = OP_SQRT;
      S_SQRT_WAIT: cmd_o.op = sts_i.done ? OP_SQRT_TAKE : OP_NONE;
      S_FMAG_MUL:  cmd_o.op = OP_MUL_FMAG;
      S_FMAG:      cmd_o.op = OP_SET_MAG;
      S_CL_MUL:    cmd_o.op = OP_MUL_SCALE;
      S_CL_DIV:    cmd_o.op = OP_DIV_LEN;
      S_CL_SET:    cmd_o.op = OP_SET_VEL;
      S_P_MUL:     cmd_o.op = OP_MUL_DP;
      S_P_ADD:     cmd_o.op = OP_ADD_POS;
      S_DONE:      cmd_o.op = can_load ? OP_OUT : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FORCE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q <= mode_e'(mode_i);
            idx_q  <= '0;
            case (mode_e'(mode_i))
              MODE_FORCE:    state_q <= S_FADD;
              MODE_FRICTION: state_q <= S_SQX;
              MODE_STEP:     state_q <= S_DV_MUL;
              default:       state_q <= S_DONE;
            endcase
          end
        end
        S_FADD:    state_q <= S_DONE;
        S_DV_MUL:  state_q <= S_DV_DIV;
        S_DV_DIV:  state_q <= S_DV_WAIT;
        S_DV_WAIT: if (sts_i.done) state_q <= S_DV_ADD;
        S_DV_ADD: begin
          if (idx_q == IDX_LAST_XYZ) begin
            idx_q   <= '0;
            state_q <= S_SQX;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_DV_MUL;
          end
        end
        S_SQX:     state_q <= S_SQY;
        S_SQY:     state_q <= S_SQS;
        S_SQS:     state_q <= fric ? S_CMP_ONE : S_LIM2;
        S_LIM2:    state_q <= S_CMP_LIM;
        S_CMP_LIM: state_q <= S_BRANCH;
        S_CMP_ONE: state_q <= S_BRANCH;
        S_BRANCH: begin
          idx_q <= '0;
          if (sts_i.cond) state_q <= S_SQRT;
          else            state_q <= fric ? S_DONE : S_P_MUL;
        end
        S_SQRT:      state_q <= S_SQRT_WAIT;
        S_SQRT_WAIT: if (sts_i.done) state_q <= fric ? S_FMAG_MUL : S_CL_MUL;
        S_FMAG_MUL:  state_q <= S_FMAG;
        S_FMAG:      state_q <= S_CL_MUL;
        S_CL_MUL:    state_q <= S_CL_DIV;
        S_CL_DIV:    state_q <= S_CL_WAIT;
        S_CL_WAIT:   if (sts_i.done) state_q <= S_CL_SET;
        S_CL_SET: begin
          if (idx_q == IDX_LAST_XY) begin
            idx_q   <= '0;
            state_q <= fric ? S_DONE : S_P_MUL;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_CL_MUL;
          end
        end
        S_P_MUL: state_q <= S_P_ADD;
        S_P_ADD: begin
          if (idx_q == IDX_LAST_XYZ) begin
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_P_MUL;
          end
        end
        S_DONE: begin
          if (can_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[src/euler_body_integrator.sv]
// Top level of the Euler body integrator with xy speed clamp.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | input     | in_valid_i/in_stall_o | mode, force_x/y/z, time_step
//  out     | output    | out_valid_o/out_stall_i | pos_x/y/z, vel_x/y/z, flags
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One word at a time. A friction word at or below unit speed and a step word without
// a clamp skip the root unit. Step and friction words use the bit-serial divider and
// the root unit, which form one iterative unit, and a single shared multiplier.
// Reset clears the body state and loads the register defaults.
// A result waits in the output register; the next word is taken meanwhile.
`include "assert_macros.svh"
module euler_body_integrator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  ebi_pkg::word_t                 force_x_i,
  input  ebi_pkg::word_t                 force_y_i,
  input  ebi_pkg::word_t                 force_z_i,
  input  logic [ebi_pkg::DT_W-1:0]       time_step_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ebi_pkg::word_t                 pos_x_o,
  output ebi_pkg::word_t                 pos_y_o,
  output ebi_pkg::word_t                 pos_z_o,
  output ebi_pkg::word_t                 vel_x_o,
  output ebi_pkg::word_t                 vel_y_o,
  output ebi_pkg::word_t                 vel_z_o,
  output logic                           speed_limited_o,
  output logic                           saturated_o,
  input  logic                           cfg_we_i,
  input  logic [ebi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  ebi_pkg::uword_t                cfg_data_i
);
  import ebi_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  ebi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ebi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .force_x_i   (force_x_i),
    .force_y_i   (force_y_i),
    .force_z_i   (force_z_i),
    .time_step_i (time_step_i),
    .res_o       (res)
  );

  assign pos_x_o         = res.pos_x;
  assign pos_y_o         = res.pos_y;
  assign pos_z_o         = res.pos_z;
  assign vel_x_o         = res.vel_x;
  assign vel_y_o         = res.vel_y;
  assign vel_z_o         = res.vel_z;
  assign speed_limited_o = res.speed_limited;
  assign saturated_o     = res.saturated;

  `EBI_ASSERT(a_accept_capture, clk_i, rst_ni, (in_valid_i && !in_stall_o) |-> (cmd.op == OP_CAPTURE))
  `EBI_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `EBI_ASSERT(a_iter_start_free, clk_i, rst_ni, (cmd.op == OP_DIV_MASS || cmd.op == OP_DIV_LEN || cmd.op == OP_SQRT) |-> !sts.busy)
  `EBI_ASSERT_ALWAYS(a_out_load_free, clk_i, (cmd.op == OP_OUT) |-> (!out_valid_o || !out_stall_i))

endmodule

[test/tb_top.sv]
// Self-checking testbench for the Euler body integrator: random and directed words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ebi_pkg::*;

  localparam int  HALF_PERIOD = 6;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  MAX_GAP     = 17;
  localparam int  LONG_HOLD   = 3000;
  localparam int  DRAIN_WAIT  = 40;

  class body_scoreboard;
    res_t state_q[$];
    int   errors = 0;

    function void note(res_t r);
      state_q.push_back(r);
    endfunction

    function int pending();
      return state_q.size();
    endfunction

    function void cmp(string field, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch expected %0d actual %0d", $time, field, e, a);
      end
    endfunction

    function void check(res_t a);
      res_t e;
      if (state_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word pos_x %0d", $time, a.pos_x);
        return;
      end
      e = state_q.pop_front();
      cmp("pos_x", e.pos_x, a.pos_x);
      cmp("pos_y", e.pos_y, a.pos_y);
      cmp("pos_z", e.pos_z, a.pos_z);
      cmp("vel_x", e.vel_x, a.vel_x);
      cmp("vel_y", e.vel_y, a.vel_y);
      cmp("vel_z", e.vel_z, a.vel_z);
      cmp("speed_limited", e.speed_limited, a.speed_limited);
      cmp("saturated", e.saturated, a.saturated);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  mode_e       mode = MODE_FORCE;
  word_t       fx = '0, fy = '0, fz = '0;
  logic [DT_W-1:0] dt = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  res_t        dut_res;
  logic        cfg_we = 1'b0;
  cfg_reg_e    cfg_idx = REG_MASS;
  uword_t      cfg_data = '0;

  body_scoreboard sb = new();
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;

  // body model state
  longint force_acc[3], vel[3], pos[3];
  longint unsigned mass_reg, speed_lim_reg, fric_reg;
  bit sat_flag;

  always #(HALF_PERIOD) clk = ~clk;

  euler_body_integrator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .force_x_i(fx), .force_y_i(fy), .force_z_i(fz), .time_step_i(dt),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pos_x_o(dut_res.pos_x), .pos_y_o(dut_res.pos_y), .pos_z_o(dut_res.pos_z),
    .vel_x_o(dut_res.vel_x), .vel_y_o(dut_res.vel_y), .vel_z_o(dut_res.vel_z),
    .speed_limited_o(dut_res.speed_limited), .saturated_o(dut_res.saturated),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  function automatic longint sat_w(longint x);
    if (x > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned sq_mag(longint a);
    longint unsigned m;
    m = (a < 0) ? longint'(-a) : a;
    return m * m;
  endfunction

  function automatic res_t integrate_word(mode_e m, word_t f0, word_t f1, word_t f2,
                                          logic [DT_W-1:0] t);
    res_t r;
    longint step_dt, ms, lim, spd, len, mag;
    longint unsigned s2;
    longint fin[3];
    bit limited;
    step_dt = longint'(t);
    limited = 1'b0;
    sat_flag = 1'b0;
    fin[0] = f0; fin[1] = f1; fin[2] = f2;
    case (m)
      MODE_FORCE: begin
        for (int i = 0; i < 3; i++) force_acc[i] = sat_w(force_acc[i] + fin[i]);
      end
      MODE_FRICTION: begin
        s2 = sq_mag(vel[0]) + sq_mag(vel[1]);
        if (s2 > (64'd1 << (2 * FRAC_BITS))) begin
          len = longint'(int_sqrt(s2));
          mag = longint'((fric_reg * longint'(step_dt)) >> FRAC_BITS);
          if (mag > len) mag = len;
          vel[0] = vel[0] - (vel[0] * mag) / len;
          vel[1] = vel[1] - (vel[1] * mag) / len;
        end
      end
      MODE_STEP: begin
        ms = (mass_reg == 0) ? 64'sd1 : longint'(mass_reg);
        lim = longint'(speed_lim_reg);
        for (int i = 0; i < 3; i++)
          vel[i] = sat_w(vel[i] + sat_w((force_acc[i] * step_dt) / ms));
        s2 = sq_mag(vel[0]) + sq_mag(vel[1]);
        if (s2 > speed_lim_reg * speed_lim_reg) begin
          spd = longint'(int_sqrt(s2));
          vel[0] = sat_w((vel[0] * lim) / spd);
          vel[1] = sat_w((vel[1] * lim) / spd);
          limited = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
          pos[i] = sat_w(pos[i] + (vel[i] * step_dt) / (64'sd1 << FRAC_BITS));
          force_acc[i] = 0;
        end
      end
      default: ;
    endcase
    r.pos_x = word_t'(pos[0]); r.pos_y = word_t'(pos[1]); r.pos_z = word_t'(pos[2]);
    r.vel_x = word_t'(vel[0]); r.vel_y = word_t'(vel[1]); r.vel_z = word_t'(vel[2]);
    r.speed_limited = limited;
    r.saturated = sat_flag;
    return r;
  endfunction

  function automatic word_t rand_force();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom());
      1: return word_t'(32'h7FFFFFFF);
      2: return word_t'(32'h80000000);
      3: return '0;
      default: return word_t'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return DT_W'($urandom());
      1: return '1;
      2: return '0;
      default: return DT_W'($urandom_range(0, 32'h00020000));
    endcase
  endfunction

  task automatic send_word(mode_e m, word_t f0, word_t f1, word_t f2, logic [DT_W-1:0] t);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m; fx <= f0; fy <= f1; fz <= f2; dt <= t;
    do @(posedge clk); while (in_stall);
    sb.note(integrate_word(m, f0, f1, f2, t));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, uword_t val);
    drain();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MASS:      mass_reg = val;
      REG_MAX_SPEED: speed_lim_reg = val & 32'h7FFFFFFF;
      default:       fric_reg = val & 32'h7FFFFFFF;
    endcase
  endtask

  task automatic random_words(int n);
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 9))
        0: begin
          send_word(mode_e'($urandom_range(0, 3)), word_t'($urandom()), word_t'($urandom()),
                    word_t'($urandom()), DT_W'($urandom()));
          k++;
        end
        1, 2: begin
          send_word(MODE_FRICTION, rand_force(), rand_force(), rand_force(), rand_dt());
          k++;
        end
        default: begin
          repeat ($urandom_range(0, 3)) begin
            send_word(MODE_FORCE, rand_force(), rand_force(), rand_force(), rand_dt());
            k++;
          end
          send_word(MODE_STEP, rand_force(), rand_force(), rand_force(), rand_dt());
          k++;
        end
      endcase
    end
  endtask

  // result side
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check(dut_res);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    mass_reg = MASS_RST;
    speed_lim_reg = SPEED_RST;
    fric_reg = 0;
    for (int i = 0; i < 3; i++) begin
      force_acc[i] = 0; vel[i] = 0; pos[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every mode, ignored fields
    send_word(MODE_UNUSED, '1, '1, '1, '1);
    send_word(MODE_FORCE, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, '1);
    send_word(MODE_FORCE, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, '0);
    send_word(MODE_STEP, 32'h12345678, 32'h0, 32'h0, 24'h010000);
    send_word(MODE_FRICTION, '1, '1, '1, 24'h008000);
    send_word(MODE_STEP, '0, '0, '0, '1);
    send_word(MODE_STEP, '0, '0, '0, '0);
    send_word(MODE_FORCE, 32'h00001000, 32'hFFFFF000, 32'h00000001, 24'h000001);
    send_word(MODE_STEP, '0, '0, '0, 24'h000100);
    send_word(MODE_UNUSED, '0, '0, '0, '0);
    write_reg(REG_FRICTION, 32'h7FFFFFFF);
    send_word(MODE_FRICTION, '0, '0, '0, '1);
    send_word(MODE_FRICTION, '0, '0, '0, 24'h000001);
    write_reg(REG_MASS, '0);
    send_word(MODE_FORCE, 32'h00000003, 32'hFFFFFFFD, 32'h00000001, '0);
    send_word(MODE_STEP, '0, '0, '0, 24'h000002);
    write_reg(REG_MAX_SPEED, '0);
    send_word(MODE_STEP, '0, '0, '0, 24'h000010);

    write_reg(REG_MASS, MASS_RST);
    write_reg(REG_MAX_SPEED, SPEED_RST);
    write_reg(REG_FRICTION, 32'h00008000);
    random_words(180);

    hold_req = 1'b1;
    random_words(20);
    drain();
    random_words(60);

    write_reg(REG_MASS, 32'hFFFFFFFF);
    write_reg(REG_MAX_SPEED, 32'h7FFFFFFF);
    write_reg(REG_FRICTION, '0);
    random_words(180);

    write_reg(REG_MASS, 32'h00000001);
    write_reg(REG_MAX_SPEED, 32'h00050000);
    write_reg(REG_FRICTION, 32'h7FFFFFFF);
    random_words(180);

    write_reg(REG_MASS, $urandom());
    write_reg(REG_MAX_SPEED, $urandom() & 32'h7FFFFFFF);
    write_reg(REG_FRICTION, $urandom_range(0, 32'h00100000));
    random_words(180);

    write_reg(REG_MASS, '0);
    write_reg(REG_MAX_SPEED, '0);
    write_reg(REG_FRICTION, $urandom() & 32'h7FFFFFFF);
    random_words(120);

    write_reg(REG_MASS, 32'h00040000);
    write_reg(REG_MAX_SPEED, 32'h00C80000);
    write_reg(REG_FRICTION, 32'h00020000);
    random_words(180);

    drain();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/ebi_pkg.sv
src/ebi_iter.sv
src/ebi_dp.sv
src/ebi_ctrl.sv
src/euler_body_integrator.sv
test/tb_top.sv
